// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define MPK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MPK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mpk_pkg.sv =====
package mpk_pkg;

  localparam int MAX_CODE_BITS_DEF = 8;

  // Widths of the internal timers and configuration fields.
  localparam int UNIT_W   = 8;
  localparam int RATIO_W  = 10;
  localparam int WEIGHT_W = 7;
  localparam int QSK_W    = 8;
  localparam int MODE_W   = 2;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CODE_W   = 16;
  localparam int MARK_W   = 13;
  localparam int SPACE_W  = 9;
  localparam int GAP_W    = 10;
  localparam int P1_W     = UNIT_W + WEIGHT_W;
  localparam int BASE_W   = 10;
  localparam int MPROD_W  = BASE_W + RATIO_W;

  // Reciprocal constants: x/50 = (x*DIV50_MUL) >> DIV50_SH for x < 2**15,
  // x/100 = (x*DIV100_MUL) >> DIV100_SH for x < 2**20.
  localparam logic [16:0] DIV50_MUL  = 17'd83887;
  localparam int          DIV50_SH   = 22;
  localparam logic [20:0] DIV100_MUL = 21'd1342178;
  localparam int          DIV100_SH  = 27;

  localparam logic [RATIO_W-1:0] DIT_FACTOR = 10'd100;
  localparam logic [CODE_W-1:0]  WORD_SPACE_CODE = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAH_RATIO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QSK_COMP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYER_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ENABLE = 3'd5;

  // Keyer modes.
  localparam logic [MODE_W-1:0] MODE_IAMBIC_A  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IAMBIC_B  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ULTIMATIC = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [UNIT_W-1:0]   UNIT_RST   = 8'd48;
  localparam logic [RATIO_W-1:0]  RATIO_RST  = 10'd300;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 7'd50;
  localparam logic [QSK_W-1:0]    QSK_RST    = 8'd0;
  localparam logic [MODE_W-1:0]   MODE_RST   = MODE_IAMBIC_B;

  localparam logic [1:0] PADDLE_SQUEEZE = 2'b11;

  typedef enum logic [1:0] {
    EL_NONE = 2'd0,
    EL_DIT  = 2'd1,
    EL_DAH  = 2'd2
  } el_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_BASE,
    ST_MPROD,
    ST_MARK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic step;
    logic calc_base;
    logic calc_mprod;
    logic calc_mark;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic start;
  } status_t;

endpackage

// ===== design/mpk_ctrl.sv =====
module mpk_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mpk_pkg::status_t status,
  output mpk_pkg::cmd_t    cmd
);

  mpk_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpk_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      mpk_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = mpk_pkg::ST_STEP;
        end
      end
      mpk_pkg::ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = status.start ? mpk_pkg::ST_BASE : mpk_pkg::ST_FINISH;
      end
      mpk_pkg::ST_BASE: begin
        cmd.calc_base = 1'b1;
        state_nxt     = mpk_pkg::ST_MPROD;
      end
      mpk_pkg::ST_MPROD: begin
        cmd.calc_mprod = 1'b1;
        state_nxt      = mpk_pkg::ST_MARK;
      end
      mpk_pkg::ST_MARK: begin
        cmd.calc_mark = 1'b1;
        state_nxt     = mpk_pkg::ST_FINISH;
      end
      mpk_pkg::ST_FINISH: begin
        // The result register must be empty or emptying this cycle.
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mpk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mpk_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != mpk_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== design/mpk_dpath.sv =====
module mpk_dpath #(
  parameter int MAX_CODE_BITS = mpk_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mpk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpk_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [1:0]                      in_paddle,
  input  mpk_pkg::cmd_t                   cmd,
  output mpk_pkg::status_t                status,
  output logic                            out_key_line,
  output logic                            out_tone_on,
  output logic                            out_busy_res,
  output logic                            out_code_valid,
  output logic [mpk_pkg::CODE_W-1:0]      out_code
);

  localparam int COLL_W = MAX_CODE_BITS + 1;

  // Configuration.
  logic [mpk_pkg::UNIT_W-1:0]   unit_r, unit_nxt;
  logic [mpk_pkg::RATIO_W-1:0]  ratio_r, ratio_nxt;
  logic [mpk_pkg::WEIGHT_W-1:0] weight_r, weight_nxt;
  logic [mpk_pkg::QSK_W-1:0]    qsk_r, qsk_nxt;
  logic [mpk_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic                         key_en_r, key_en_nxt;

  // Keyer state.
  logic [1:0]                   paddle_r, paddle_nxt;
  logic [mpk_pkg::MARK_W-1:0]   mark_r, mark_nxt;
  logic [mpk_pkg::SPACE_W-1:0]  space_r, space_nxt;
  mpk_pkg::el_t                 cur_r, cur_nxt;
  mpk_pkg::el_t                 last_r, last_nxt;
  mpk_pkg::el_t                 el_r, el_nxt;
  logic [1:0]                   im_r, im_nxt;
  logic [1:0]                   um_r, um_nxt;
  logic [COLL_W-1:0]            coll_r, coll_nxt;
  logic [mpk_pkg::GAP_W-1:0]    gap_r, gap_nxt;
  logic                         key_r, key_nxt;
  logic                         tv_r, tv_nxt;
  logic [mpk_pkg::CODE_W-1:0]   tc_r, tc_nxt;

  // Timing arithmetic.
  logic [mpk_pkg::P1_W-1:0]     p1_r, p1_nxt;
  logic [mpk_pkg::BASE_W-1:0]   base_r, base_nxt;
  logic [mpk_pkg::MPROD_W-1:0]  mprod_r, mprod_nxt;

  // Result register.
  logic                         o_key_r, o_key_nxt;
  logic                         o_tone_r, o_tone_nxt;
  logic                         o_busy_r, o_busy_nxt;
  logic                         o_cv_r, o_cv_nxt;
  logic [mpk_pkg::CODE_W-1:0]   o_code_r, o_code_nxt;

  // Combinational helpers.
  logic                         choose;
  logic [1:0]                   im_t;
  logic [1:0]                   p;
  mpk_pkg::el_t                 el;
  logic [COLL_W-1:0]            coll_seed;
  logic [31:0]                  prod50;
  logic [mpk_pkg::RATIO_W-1:0]  factor;
  logic [mpk_pkg::SPACE_W-1:0]  two_unit;
  logic [40:0]                  prod100;
  logic [mpk_pkg::MARK_W:0]     mark_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r   <= mpk_pkg::UNIT_RST;
      ratio_r  <= mpk_pkg::RATIO_RST;
      weight_r <= mpk_pkg::WEIGHT_RST;
      qsk_r    <= mpk_pkg::QSK_RST;
      mode_r   <= mpk_pkg::MODE_RST;
      key_en_r <= 1'b1;
      mark_r   <= '0;
      space_r  <= '0;
      cur_r    <= mpk_pkg::EL_NONE;
      last_r   <= mpk_pkg::EL_NONE;
      im_r     <= '0;
      um_r     <= '0;
      coll_r   <= '0;
      gap_r    <= '0;
      key_r    <= 1'b0;
    end else begin
      unit_r   <= unit_nxt;
      ratio_r  <= ratio_nxt;
      weight_r <= weight_nxt;
      qsk_r    <= qsk_nxt;
      mode_r   <= mode_nxt;
      key_en_r <= key_en_nxt;
      mark_r   <= mark_nxt;
      space_r  <= space_nxt;
      cur_r    <= cur_nxt;
      last_r   <= last_nxt;
      im_r     <= im_nxt;
      um_r     <= um_nxt;
      coll_r   <= coll_nxt;
      gap_r    <= gap_nxt;
      key_r    <= key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    paddle_r <= paddle_nxt;
    el_r     <= el_nxt;
    tv_r     <= tv_nxt;
    tc_r     <= tc_nxt;
    p1_r     <= p1_nxt;
    base_r   <= base_nxt;
    mprod_r  <= mprod_nxt;
    o_key_r  <= o_key_nxt;
    o_tone_r <= o_tone_nxt;
    o_busy_r <= o_busy_nxt;
    o_cv_r   <= o_cv_nxt;
    o_code_r <= o_code_nxt;
  end

  always_comb begin
    unit_nxt   = unit_r;
    ratio_nxt  = ratio_r;
    weight_nxt = weight_r;
    qsk_nxt    = qsk_r;
    mode_nxt   = mode_r;
    key_en_nxt = key_en_r;
    paddle_nxt = paddle_r;
    mark_nxt   = mark_r;
    space_nxt  = space_r;
    cur_nxt    = cur_r;
    last_nxt   = last_r;
    el_nxt     = el_r;
    im_nxt     = im_r;
    um_nxt     = um_r;
    coll_nxt   = coll_r;
    gap_nxt    = gap_r;
    key_nxt    = key_r;
    tv_nxt     = tv_r;
    tc_nxt     = tc_r;
    p1_nxt     = p1_r;
    base_nxt   = base_r;
    mprod_nxt  = mprod_r;
    o_key_nxt  = o_key_r;
    o_tone_nxt = o_tone_r;
    o_busy_nxt = o_busy_r;
    o_cv_nxt   = o_cv_r;
    o_code_nxt = o_code_r;
    status     = '0;
    choose     = 1'b1;
    im_t       = im_r;
    p          = paddle_r;
    el         = mpk_pkg::EL_NONE;
    coll_seed  = '0;
    factor     = (el_r == mpk_pkg::EL_DAH) ? ratio_r : mpk_pkg::DIT_FACTOR;
    two_unit   = {unit_r, 1'b0};
    prod50     = {17'd0, p1_r} * {15'd0, mpk_pkg::DIV50_MUL};
    prod100    = {21'd0, mprod_r} * {20'd0, mpk_pkg::DIV100_MUL};
    mark_sum   = {1'b0, prod100[mpk_pkg::DIV100_SH +: mpk_pkg::MARK_W]}
               + {{(mpk_pkg::MARK_W + 1 - mpk_pkg::QSK_W){1'b0}}, qsk_r};

    if (cfg_we) begin
      case (cfg_index)
        mpk_pkg::CFG_UNIT_MS:   unit_nxt   = cfg_wdata[mpk_pkg::UNIT_W-1:0];
        mpk_pkg::CFG_DAH_RATIO: ratio_nxt  = cfg_wdata[mpk_pkg::RATIO_W-1:0];
        mpk_pkg::CFG_WEIGHTING: weight_nxt = cfg_wdata[mpk_pkg::WEIGHT_W-1:0];
        mpk_pkg::CFG_QSK_COMP:  qsk_nxt    = cfg_wdata[mpk_pkg::QSK_W-1:0];
        mpk_pkg::CFG_KEYER_MODE: begin
          mode_nxt = cfg_wdata[mpk_pkg::MODE_W-1:0];
          im_nxt   = '0;
          um_nxt   = '0;
        end
        mpk_pkg::CFG_KEY_ENABLE: key_en_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    if (cmd.load_in) begin
      paddle_nxt = in_paddle;
    end

    if (cmd.step) begin
      tv_nxt = 1'b0;
      tc_nxt = '0;
      p1_nxt = {{mpk_pkg::WEIGHT_W{1'b0}}, unit_r} * {{mpk_pkg::UNIT_W{1'b0}}, weight_r};

      if (gap_r != '0) begin
        if (gap_r == mpk_pkg::GAP_W'(1)) begin
          tv_nxt  = 1'b1;
          tc_nxt  = mpk_pkg::WORD_SPACE_CODE;
          gap_nxt = '0;
        end else begin
          gap_nxt = gap_r - mpk_pkg::GAP_W'(1);
        end
      end

      if (mark_r != '0) begin
        mark_nxt = mark_r - mpk_pkg::MARK_W'(1);
        if (mark_r == mpk_pkg::MARK_W'(1)) begin
          key_nxt = 1'b0;
          im_t    = '0;
        end
        choose = 1'b0;
      end else if (space_r != '0) begin
        im_t      = im_r | paddle_r;
        space_nxt = space_r - mpk_pkg::SPACE_W'(1);
        if (space_r != mpk_pkg::SPACE_W'(1)) begin
          choose = 1'b0;
        end else begin
          last_nxt = cur_r;
          cur_nxt  = mpk_pkg::EL_NONE;
        end
      end
      im_nxt = im_t;

      if (choose) begin
        if (mode_r == mpk_pkg::MODE_ULTIMATIC) begin
          p      = (um_r ^ paddle_r) & paddle_r;
          um_nxt = p;
        end else if (mode_r == mpk_pkg::MODE_IAMBIC_B && paddle_r == 2'b00) begin
          p = im_t;
        end
        if (p == mpk_pkg::PADDLE_SQUEEZE) begin
          el = (last_nxt == mpk_pkg::EL_DIT) ? mpk_pkg::EL_DAH : mpk_pkg::EL_DIT;
        end else begin
          el = mpk_pkg::el_t'(p);
        end

        // Gather the element into the code, or flush it when idle.
        if (el == mpk_pkg::EL_NONE) begin
          if (coll_r != '0) begin
            tv_nxt   = 1'b1;
            tc_nxt   = mpk_pkg::CODE_W'(coll_r);
            coll_nxt = '0;
            gap_nxt  = {unit_r, 2'b00} + mpk_pkg::GAP_W'(1);
          end
        end else begin
          gap_nxt = '0;
          if (!coll_r[MAX_CODE_BITS]) begin
            coll_seed = (coll_r == '0) ? COLL_W'(1) : coll_r;
            coll_nxt  = {coll_seed[MAX_CODE_BITS-1:0], el == mpk_pkg::EL_DAH};
          end
        end

        cur_nxt = el;
        el_nxt  = el;
        im_nxt  = '0;
        if (el == mpk_pkg::EL_NONE) begin
          mark_nxt  = '0;
          space_nxt = '0;
          key_nxt   = 1'b0;
        end else begin
          status.start = 1'b1;
        end
      end
    end

    if (cmd.calc_base) begin
      base_nxt = prod50[mpk_pkg::DIV50_SH +: mpk_pkg::BASE_W];
    end

    if (cmd.calc_mprod) begin
      mprod_nxt = {{mpk_pkg::RATIO_W{1'b0}}, base_r} * {{mpk_pkg::BASE_W{1'b0}}, factor};
      space_nxt = (base_r > {1'b0, two_unit}) ? '0
                : mpk_pkg::SPACE_W'({1'b0, two_unit} - base_r);
    end

    if (cmd.calc_mark) begin
      mark_nxt = mark_sum[mpk_pkg::MARK_W-1:0];
      key_nxt  = (mark_sum != '0);
    end

    if (cmd.load_out) begin
      o_key_nxt  = key_r & key_en_r;
      o_tone_nxt = key_r;
      o_busy_nxt = (cur_r != mpk_pkg::EL_NONE);
      o_cv_nxt   = tv_r;
      o_code_nxt = tv_r ? tc_r : '0;
    end
  end

  assign out_key_line   = o_key_r;
  assign out_tone_on    = o_tone_r;
  assign out_busy_res   = o_busy_r;
  assign out_code_valid = o_cv_r;
  assign out_code       = o_code_r;

endmodule

// ===== design/morse_paddle_keyer.sv =====
// Iambic Morse paddle keyer, advanced by one request per millisecond tick.
// Input channel: in_valid / in_stall carry in_paddle (bit 0 dit contact,
// bit 1 dah contact). Each accepted request yields exactly one result on the
// output channel (out_valid / out_stall): key line, sidetone, busy flag and,
// when out_code_valid is high, a collected start-bit code or the word-space
// marker 0xFFFF.
// A tick that starts no new element runs the step and finish states; one that
// does also runs the base, mark-product and mark states to time the mark and
// space (divide by 50, weight by the dah ratio or 100 for a dit, divide by 100).
// One request is in flight at a time; the next waits for the last result to load.
// The result register decouples the two sides: a new request is accepted while
// the previous result still waits; a stalled result holds its value, and the
// next result waits in the controller until the register is free.
// Reset (rst_n low, synchronous) loads the default configuration (48 ms unit,
// dah ratio 300, weighting 50, no QSK compensation, iambic B, keying enabled)
// and clears all timers and collected code. Configuration is written through
// cfg_we / cfg_index / cfg_wdata; the user must write it only while no request
// is in flight, as the block itself does not enforce this.
module morse_paddle_keyer #(
  parameter int MAX_CODE_BITS = mpk_pkg::MAX_CODE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mpk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpk_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_paddle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_key_line,
  output logic                          out_tone_on,
  output logic                          out_busy_res,
  output logic                          out_code_valid,
  output logic [mpk_pkg::CODE_W-1:0]    out_code
);

  // Commands from the controller step the datapath through one tick; the
  // datapath reports whether the tick has started a new element.
  mpk_pkg::cmd_t    cmd;
  mpk_pkg::status_t status;

  mpk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mpk_dpath #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_paddle      (in_paddle),
    .cmd            (cmd),
    .status         (status),
    .out_key_line   (out_key_line),
    .out_tone_on    (out_tone_on),
    .out_busy_res   (out_busy_res),
    .out_code_valid (out_code_valid),
    .out_code       (out_code)
  );

endmodule

// ===== design/mpk_checker.sv =====
`include "assert_macros.svh"

module mpk_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_key_line,
  input logic                       out_tone_on,
  input logic                       out_busy_res,
  input logic                       out_code_valid,
  input logic [mpk_pkg::CODE_W-1:0] out_code
);

  `MPK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
  `MPK_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "not idle after reset")
  `MPK_ASSERT(a_code_zero, out_valid && !out_code_valid |-> out_code == '0, "stale code")
  `MPK_ASSERT(a_key_tone, out_valid && out_key_line |-> out_tone_on, "key without sidetone")
  `MPK_ASSERT(a_tone_busy, out_valid && out_tone_on |-> out_busy_res, "key-down outside element")

endmodule

bind morse_paddle_keyer mpk_checker u_mpk_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_key_line   (out_key_line),
  .out_tone_on    (out_tone_on),
  .out_busy_res   (out_busy_res),
  .out_code_valid (out_code_valid),
  .out_code       (out_code)
);
